[hdl/esc_utf8_pkg.sv]
package esc_utf8_pkg;

    localparam int MAX_RES = 6;
    localparam int UTF8_MAX = 5;
    localparam int CP_W = 24;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] LEAD5     = 8'hF8;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [CP_W-1:0] LIM1 = 24'h00007F;
    localparam logic [CP_W-1:0] LIM2 = 24'h0007FF;
    localparam logic [CP_W-1:0] LIM3 = 24'h00FFFF;
    localparam logic [CP_W-1:0] LIM4 = 24'h1FFFFF;

    typedef enum logic [4:0] {
        M_PLAIN     = 5'd1,
        M_DOLLAR    = 5'd2,
        M_BSLASH    = 5'd3,
        M_REF_FIRST = 5'd4,
        M_U_FIRST   = 5'd5,
        M_REF_NAME  = 5'd6,
        M_U_DIG1    = 5'd7,
        M_U_DIG2    = 5'd8,
        M_U_DIG3    = 5'd9,
        M_U_DIG4    = 5'd10,
        M_U_DIG5    = 5'd11,
        M_UB_FIRST  = 5'd12,
        M_UB_DIG1   = 5'd13,
        M_UB_DIG2   = 5'd14,
        M_UB_DIG3   = 5'd15,
        M_UB_DIG4   = 5'd16,
        M_UB_DIG5   = 5'd17,
        M_UB_DIG6   = 5'd18,
        M_HOLD      = 5'd19
    } mode_t;

    typedef enum logic [2:0] {
        K_LIT     = 3'd0,
        K_REF     = 3'd1,
        K_REF_END = 3'd2,
        K_ERR     = 3'd3,
        K_END     = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        E_NONE       = 4'd0,
        E_REF_OPEN   = 4'd1,
        E_REF_EMPTY  = 4'd2,
        E_U_OPEN     = 4'd3,
        E_U_BAD      = 4'd4,
        E_UB_OPEN    = 4'd5,
        E_UB_EMPTY   = 4'd6,
        E_BAD_HEX    = 4'd7,
        E_TOO_MANY   = 4'd8
    } err_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        err_t       err;
    } res_t;

    typedef struct packed {
        logic [2:0]                len;
        logic [UTF8_MAX-1:0][7:0]  b;
    } utf8_t;

    // bit 4 flags a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch inside {[8'h30:8'h39]}) begin
            d = ch - 8'h30;
            return {1'b1, d[3:0]};
        end else if (ch inside {[8'h61:8'h66]}) begin
            d = ch - 8'h57;
            return {1'b1, d[3:0]};
        end else if (ch inside {[8'h41:8'h46]}) begin
            d = ch - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

    function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
        utf8_t u;
        u.len = 3'd0;
        u.b   = '0;
        if (cp <= LIM1) begin
            u.len  = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp <= LIM2) begin
            u.len  = 3'd2;
            u.b[0] = LEAD2 | {3'b000, cp[10:6]};
            u.b[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp <= LIM3) begin
            u.len  = 3'd3;
            u.b[0] = LEAD3 | {4'h0, cp[15:12]};
            u.b[1] = CONT | {2'b00, cp[11:6]};
            u.b[2] = CONT | {2'b00, cp[5:0]};
        end else if (cp <= LIM4) begin
            u.len  = 3'd4;
            u.b[0] = LEAD4 | {5'b00000, cp[20:18]};
            u.b[1] = CONT | {2'b00, cp[17:12]};
            u.b[2] = CONT | {2'b00, cp[11:6]};
            u.b[3] = CONT | {2'b00, cp[5:0]};
        end else begin
            u.len  = 3'd5;
            u.b[0] = LEAD5;
            u.b[1] = CONT | {2'b00, cp[23:18]};
            u.b[2] = CONT | {2'b00, cp[17:12]};
            u.b[3] = CONT | {2'b00, cp[11:6]};
            u.b[4] = CONT | {2'b00, cp[5:0]};
        end
        return u;
    endfunction

endpackage

[hdl/escape_sequence_utf8_decoder.sv]
// the first result of an input transaction is offered in the cycle after it is accepted
// throughput: one input transaction per cycle while each gives at most one result and m_tready is high;
//   a transaction with k results holds the output until all k are taken (k up to 5, a utf-8 burst)
// the result buffer drains one entry a cycle while m_tready is high and takes the next transaction on its last beat
// reset: aresetn low at a rising edge empties the buffer, returns to plain text, clears code point
module escape_sequence_utf8_decoder
    import esc_utf8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value_byte
    input  logic        s_tlast,   // is_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_item
);

    // parser state
    mode_t              mode_reg, mode_next;
    logic [CP_W-1:0]    cp_reg, cp_next;

    // result buffer, loaded whole on accept, read out one entry per beat
    res_t               buf_reg [MAX_RES];
    logic [2:0]         cnt_reg;
    logic [2:0]         rd_reg;

    // decode of the incoming byte
    logic [7:0]         in_ch;
    logic               in_end;
    logic [4:0]         hex_dec;
    logic               hex_ok;
    logic [3:0]         hex_nib;
    logic [CP_W-1:0]    cp_shift;

    // utf-8 flush of a pending code point, always the first results of a transaction
    logic               utf_en;
    logic [CP_W-1:0]    utf_cp;
    utf8_t              utf;

    res_t               res [MAX_RES];
    logic [2:0]         res_cnt;
    logic               do_plain;
    logic               do_finish;

    logic               s_accept;
    logic               m_accept;
    logic               m_last_beat;

    assign in_ch    = s_tdata;
    assign in_end   = s_tlast || (s_tdata == 8'h00);
    assign hex_dec  = hex_decode(in_ch);
    assign hex_ok   = hex_dec[4] && !in_end;
    assign hex_nib  = hex_dec[3:0];
    assign cp_shift = {cp_reg[CP_W-5:0], hex_nib};

    // handshakes
    assign m_tvalid    = (rd_reg != cnt_reg);
    assign m_last_beat = (rd_reg == (cnt_reg - 3'd1));
    assign m_accept    = m_tvalid && m_tready;
    assign s_tready    = !m_tvalid || (m_tready && m_last_beat);
    assign s_accept    = s_tvalid && s_tready;

    assign m_tdata = {4'h0, buf_reg[rd_reg[2:0]].err, buf_reg[rd_reg[2:0]].data};
    assign m_tuser = buf_reg[rd_reg[2:0]].kind;
    assign m_tlast = m_last_beat;

    // which code point, if any, gets encoded ahead of the other results
    always_comb begin
        utf_en = 1'b0;
        utf_cp = cp_reg;
        case (mode_reg)
            M_U_DIG1, M_U_DIG2, M_U_DIG3, M_U_DIG4: begin
                utf_en = !hex_ok;
            end
            M_U_DIG5: begin
                utf_en = 1'b1;
                utf_cp = hex_ok ? cp_shift : cp_reg;
            end
            M_UB_DIG1, M_UB_DIG2, M_UB_DIG3, M_UB_DIG4, M_UB_DIG5, M_UB_DIG6: begin
                utf_en = !in_end && (in_ch == CH_RBRACE);
            end
            default: begin
                utf_en = 1'b0;
            end
        endcase
    end

    assign utf = utf8_encode(utf_cp);

    // next state and the list of results for this transaction
    always_comb begin
        mode_next = mode_reg;
        cp_next   = cp_reg;
        do_plain  = 1'b0;
        do_finish = 1'b0;
        res_cnt   = 3'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '{data: 8'h00, kind: K_LIT, err: E_NONE};
        end

        if (utf_en) begin
            for (int i = 0; i < UTF8_MAX; i++) begin
                res[i].data = utf.b[i];
            end
            res_cnt = utf.len;
        end

        case (mode_reg)
            M_PLAIN: begin
                do_finish = in_end;
                do_plain  = !in_end;
            end
            M_DOLLAR: begin
                if (!in_end && in_ch == CH_LBRACE) begin
                    mode_next = M_REF_FIRST;
                end else begin
                    res[res_cnt] = '{data: CH_DOLLAR, kind: K_LIT, err: E_NONE};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_PLAIN;
                    do_finish    = in_end;
                    do_plain     = !in_end;
                end
            end
            M_BSLASH: begin
                if (in_end) begin
                    res[res_cnt] = '{data: CH_BSLASH, kind: K_LIT, err: E_NONE};
                    res_cnt      = res_cnt + 3'd1;
                    do_finish    = 1'b1;
                end else if (in_ch == CH_U) begin
                    cp_next   = '0;
                    mode_next = M_U_FIRST;
                end else begin
                    res[res_cnt].data = (in_ch == CH_N) ? CH_LF :
                                        (in_ch == CH_T) ? CH_TAB :
                                        (in_ch == CH_R) ? CH_CR : in_ch;
                    res_cnt   = res_cnt + 3'd1;
                    mode_next = M_PLAIN;
                end
            end
            M_REF_FIRST: begin
                if (in_end) begin
                    res[res_cnt] = '{data: 8'h00, kind: K_ERR, err: E_REF_OPEN};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_HOLD;
                    cp_next      = '0;
                    do_finish    = 1'b1;
                end else if (in_ch == CH_RBRACE) begin
                    res[res_cnt] = '{data: 8'h00, kind: K_ERR, err: E_REF_EMPTY};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_HOLD;
                    cp_next      = '0;
                end else begin
                    res[res_cnt] = '{data: in_ch, kind: K_REF, err: E_NONE};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_REF_NAME;
                end
            end
            M_REF_NAME: begin
                if (in_end) begin
                    res[res_cnt] = '{data: 8'h00, kind: K_ERR, err: E_REF_OPEN};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_HOLD;
                    cp_next      = '0;
                    do_finish    = 1'b1;
                end else if (in_ch == CH_RBRACE) begin
                    res[res_cnt] = '{data: 8'h00, kind: K_REF_END, err: E_NONE};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_PLAIN;
                end else begin
                    res[res_cnt] = '{data: in_ch, kind: K_REF, err: E_NONE};
                    res_cnt      = res_cnt + 3'd1;
                end
            end
            M_U_FIRST: begin
                if (in_end) begin
                    res[res_cnt] = '{data: 8'h00, kind: K_ERR, err: E_U_OPEN};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_HOLD;
                    cp_next      = '0;
                    do_finish    = 1'b1;
                end else if (in_ch == CH_LBRACE) begin
                    mode_next = M_UB_FIRST;
                end else if (hex_ok) begin
                    cp_next   = {{(CP_W-4){1'b0}}, hex_nib};
                    mode_next = M_U_DIG1;
                end else begin
                    res[res_cnt] = '{data: 8'h00, kind: K_ERR, err: E_U_BAD};
                    res_cnt      = res_cnt + 3'd1;
                    mode_next    = M_HOLD;
                    cp_next      = '0;
                end
            end
            M_U_DIG1, M_U_DIG2, M_U_DIG3, M_U_DIG4: begin
                if (hex_ok) begin
                    cp_next   = cp_shift;
                    mode_next = mode_t'(mode_reg + 5'd1);
                end else begin
                    cp_next   = '0;
                    mode_next = M_PLAIN;
                    do_finish = in_end;
                    do_plain  = !in_end;
                end
            end
            M_U_DIG5: begin
                cp_next   = '0;
                mode_next = M_PLAIN;
                do_finish = !hex_ok && in_end;
                do_plain  = !hex_ok && !in_end;
            end
            M_UB_FIRST: begin
                if (in_end || in_ch == CH_RBRACE || !hex_ok) begin
                    res[res_cnt].kind = K_ERR;
                    res[res_cnt].err  = in_end ? E_UB_OPEN :
                                        (in_ch == CH_RBRACE) ? E_UB_EMPTY : E_BAD_HEX;
                    res_cnt   = res_cnt + 3'd1;
                    mode_next = M_HOLD;
                    cp_next   = '0;
                    do_finish = in_end;
                end else begin
                    cp_next   = {{(CP_W-4){1'b0}}, hex_nib};
                    mode_next = M_UB_DIG1;
                end
            end
            M_UB_DIG1, M_UB_DIG2, M_UB_DIG3, M_UB_DIG4, M_UB_DIG5, M_UB_DIG6: begin
                if (!in_end && in_ch == CH_RBRACE) begin
                    cp_next   = '0;
                    mode_next = M_PLAIN;
                end else if (hex_ok && mode_reg != M_UB_DIG6) begin
                    cp_next   = cp_shift;
                    mode_next = mode_t'(mode_reg + 5'd1);
                end else begin
                    res[res_cnt].kind = K_ERR;
                    res[res_cnt].err  = in_end ? E_UB_OPEN :
                                        hex_ok ? E_TOO_MANY : E_BAD_HEX;
                    res_cnt   = res_cnt + 3'd1;
                    mode_next = M_HOLD;
                    cp_next   = '0;
                    do_finish = in_end;
                end
            end
            M_HOLD: begin
                do_finish = in_end;
            end
            default: begin
                // stray code: behave as plain text
                mode_next = M_PLAIN;
                cp_next   = '0;
                do_finish = in_end;
                do_plain  = !in_end;
            end
        endcase

        // plain text handling of the byte, after any flush
        if (do_plain) begin
            if (in_ch == CH_DOLLAR) begin
                mode_next = M_DOLLAR;
            end else if (in_ch == CH_BSLASH) begin
                mode_next = M_BSLASH;
            end else begin
                res[res_cnt] = '{data: in_ch, kind: K_LIT, err: E_NONE};
                res_cnt      = res_cnt + 3'd1;
            end
        end

        // end of value closes the transaction
        if (do_finish) begin
            res[res_cnt] = '{data: 8'h00, kind: K_END, err: E_NONE};
            res_cnt      = res_cnt + 3'd1;
            mode_next    = M_PLAIN;
            cp_next      = '0;
        end
    end

    // control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_PLAIN;
            cp_reg   <= '0;
            cnt_reg  <= 3'd0;
            rd_reg   <= 3'd0;
        end else if (s_accept) begin
            mode_reg <= mode_next;
            cp_reg   <= cp_next;
            cnt_reg  <= res_cnt;
            rd_reg   <= 3'd0;
        end else if (m_accept) begin
            rd_reg   <= rd_reg + 3'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_reg[i] <= res[i];
            end
        end
    end

    // read pointer never runs past the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_reg <= cnt_reg) && (cnt_reg <= 3'(MAX_RES)))
        else $error("result buffer pointer out of range");

    // a new transaction only enters as the previous one's last result leaves
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && m_tvalid) |-> (m_tready && m_tlast))
        else $error("input accepted over pending results");

    // end of value always returns to plain text with a cleared code point
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_end) |=> (mode_reg == M_PLAIN && cp_reg == '0 && m_tvalid))
        else $error("end of value did not flush the parser");

    // after an error, bytes up to the end give nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && mode_reg == M_HOLD && !in_end) |=> (cnt_reg == 3'd0 && mode_reg == M_HOLD))
        else $error("output produced while holding after an error");

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_utf8_pkg::*;

    // cycles without any transaction on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // random input transactions to send after the directed ones
    localparam int RANDOM_ITEMS = 500;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // one predicted output beat
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        err_t       err;
        logic       last;
    } out_beat_t;

    // tracks the unescaper state and holds the beats still owed by the dut
    class unescape_scoreboard;
        mode_t       mode;
        logic [23:0] code_point;
        out_beat_t   beats_due[$];
        out_beat_t   burst[$];
        int          fail_count;
        int          beats_seen;
        int          error_beats;
        int          name_beats;
        int          bytes_used;

        function new();
            mode        = M_PLAIN;
            code_point  = '0;
            fail_count  = 0;
            beats_seen  = 0;
            error_beats = 0;
            name_beats  = 0;
            bytes_used  = 0;
        endfunction

        function int hex_val(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void put(logic [7:0] d, kind_t k, err_t e);
            out_beat_t b;
            b.data = d;
            b.kind = k;
            b.err  = e;
            b.last = 1'b0;
            if (burst.size() < MAX_RES) burst = {burst, b};
        endfunction

        // utf-8 of up to five bytes, lead byte first
        function void put_code(logic [23:0] v);
            if (v <= 24'h00007F) begin
                put(v[7:0], K_LIT, E_NONE);
            end else if (v <= 24'h0007FF) begin
                put({3'b110, v[10:6]}, K_LIT, E_NONE);
                put({2'b10, v[5:0]}, K_LIT, E_NONE);
            end else if (v <= 24'h00FFFF) begin
                put({4'b1110, v[15:12]}, K_LIT, E_NONE);
                put({2'b10, v[11:6]}, K_LIT, E_NONE);
                put({2'b10, v[5:0]}, K_LIT, E_NONE);
            end else if (v <= 24'h1FFFFF) begin
                put({5'b11110, v[20:18]}, K_LIT, E_NONE);
                put({2'b10, v[17:12]}, K_LIT, E_NONE);
                put({2'b10, v[11:6]}, K_LIT, E_NONE);
                put({2'b10, v[5:0]}, K_LIT, E_NONE);
            end else begin
                put(8'hF8, K_LIT, E_NONE);
                put({2'b10, v[23:18]}, K_LIT, E_NONE);
                put({2'b10, v[17:12]}, K_LIT, E_NONE);
                put({2'b10, v[11:6]}, K_LIT, E_NONE);
                put({2'b10, v[5:0]}, K_LIT, E_NONE);
            end
        endfunction

        function void close_value();
            put(8'h00, K_END, E_NONE);
            mode       = M_PLAIN;
            code_point = '0;
        endfunction

        function void raise(err_t e, bit at_end);
            put(8'h00, K_ERR, e);
            mode       = M_HOLD;
            code_point = '0;
            if (at_end) close_value();
        endfunction

        function void plain(logic [7:0] c);
            if (c == CH_DOLLAR) mode = M_DOLLAR;
            else if (c == CH_BSLASH) mode = M_BSLASH;
            else put(c, K_LIT, E_NONE);
        endfunction

        function void note_input(logic [7:0] c, logic tl);
            bit fin;
            int h;
            fin = tl || (c == 8'h00);
            h   = fin ? -1 : hex_val(c);
            bytes_used++;
            burst.delete();
            case (mode)
                M_PLAIN: begin
                    if (fin) close_value();
                    else plain(c);
                end
                M_DOLLAR: begin
                    if (!fin && c == CH_LBRACE) begin
                        mode = M_REF_FIRST;
                    end else begin
                        put(CH_DOLLAR, K_LIT, E_NONE);
                        mode = M_PLAIN;
                        if (fin) close_value();
                        else plain(c);
                    end
                end
                M_BSLASH: begin
                    if (fin) begin
                        put(CH_BSLASH, K_LIT, E_NONE);
                        close_value();
                    end else if (c == CH_U) begin
                        code_point = '0;
                        mode       = M_U_FIRST;
                    end else begin
                        case (c)
                            CH_N: put(CH_LF, K_LIT, E_NONE);
                            CH_T: put(CH_TAB, K_LIT, E_NONE);
                            CH_R: put(CH_CR, K_LIT, E_NONE);
                            default: put(c, K_LIT, E_NONE);
                        endcase
                        mode = M_PLAIN;
                    end
                end
                M_REF_FIRST: begin
                    if (fin) raise(E_REF_OPEN, 1'b1);
                    else if (c == CH_RBRACE) raise(E_REF_EMPTY, 1'b0);
                    else begin
                        put(c, K_REF, E_NONE);
                        mode = M_REF_NAME;
                    end
                end
                M_REF_NAME: begin
                    if (fin) raise(E_REF_OPEN, 1'b1);
                    else if (c == CH_RBRACE) begin
                        put(8'h00, K_REF_END, E_NONE);
                        mode = M_PLAIN;
                    end else put(c, K_REF, E_NONE);
                end
                M_U_FIRST: begin
                    if (fin) raise(E_U_OPEN, 1'b1);
                    else if (c == CH_LBRACE) mode = M_UB_FIRST;
                    else if (h >= 0) begin
                        code_point = {20'h0, h[3:0]};
                        mode       = M_U_DIG1;
                    end else raise(E_U_BAD, 1'b0);
                end
                M_U_DIG1, M_U_DIG2, M_U_DIG3, M_U_DIG4, M_U_DIG5: begin
                    if (h >= 0) begin
                        code_point = {code_point[19:0], h[3:0]};
                        if (mode != M_U_DIG5) begin
                            mode = mode_t'(mode + 1);
                        end else begin
                            put_code(code_point);
                            code_point = '0;
                            mode       = M_PLAIN;
                        end
                    end else begin
                        // short form closed by a non-digit, which then counts as text
                        put_code(code_point);
                        code_point = '0;
                        mode       = M_PLAIN;
                        if (fin) close_value();
                        else plain(c);
                    end
                end
                M_UB_FIRST: begin
                    if (fin) raise(E_UB_OPEN, 1'b1);
                    else if (c == CH_RBRACE) raise(E_UB_EMPTY, 1'b0);
                    else if (h < 0) raise(E_BAD_HEX, 1'b0);
                    else begin
                        code_point = {20'h0, h[3:0]};
                        mode       = M_UB_DIG1;
                    end
                end
                M_UB_DIG1, M_UB_DIG2, M_UB_DIG3, M_UB_DIG4, M_UB_DIG5, M_UB_DIG6: begin
                    if (fin) raise(E_UB_OPEN, 1'b1);
                    else if (c == CH_RBRACE) begin
                        put_code(code_point);
                        code_point = '0;
                        mode       = M_PLAIN;
                    end else if (h >= 0 && mode != M_UB_DIG6) begin
                        code_point = {code_point[19:0], h[3:0]};
                        mode       = mode_t'(mode + 1);
                    end else if (h >= 0) raise(E_TOO_MANY, 1'b0);
                    else raise(E_BAD_HEX, 1'b0);
                end
                M_HOLD: begin
                    if (fin) close_value();
                end
                default: begin
                    mode       = M_PLAIN;
                    code_point = '0;
                    if (fin) close_value();
                    else plain(c);
                end
            endcase
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) beats_due = {beats_due, burst[i]};
        endfunction

        function void check_result(logic [15:0] td, logic [2:0] tu, logic tl);
            out_beat_t w;
            if (beats_due.size() == 0) begin
                $error("result transaction with nothing outstanding: byte %02h kind %0d",
                       td[7:0], tu);
                fail_count++;
                return;
            end
            w = beats_due.pop_front();
            beats_seen++;
            if (w.kind == K_ERR) error_beats++;
            if (w.kind == K_REF) name_beats++;
            if (td[7:0] !== w.data) begin
                $error("out_byte mismatch: expected %02h, actual %02h", w.data, td[7:0]);
                fail_count++;
            end
            if (tu !== w.kind) begin
                $error("kind mismatch: expected %0d, actual %0d", w.kind, tu);
                fail_count++;
            end
            if (td[11:8] !== w.err) begin
                $error("error_code mismatch: expected %0d, actual %0d", w.err, td[11:8]);
                fail_count++;
            end
            if (tl !== w.last) begin
                $error("last_of_item mismatch: expected %0b, actual %0b", w.last, tl);
                fail_count++;
            end
            if (td[15:12] !== 4'h0) begin
                $error("tdata padding mismatch: expected 0, actual %0h", td[15:12]);
                fail_count++;
            end
        endfunction
    endclass

    unescape_scoreboard sb = new();

    // largest idle gap each side may draw; zero gives a stretch at full rate
    int send_span = 18;
    int recv_span = 18;
    int stall_cycles = 0;
    int values_sent = 0;

    escape_sequence_utf8_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hex digit in either case
    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'h30 + v[7:0];
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
    endfunction

    // any non-zero byte that does not open an escape or a reference
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CH_DOLLAR || b == CH_BSLASH);
        return b;
    endfunction

    // one input transaction; valid stays high when the next one follows at once
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        gap = $urandom_range(0, send_span);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, e);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send_item(hex_char($urandom_range(0, 15)), 1'b0);
    endtask

    // hold the sender back until every owed result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.beats_due.size() > 0);
    endtask

    // one value: mostly well-formed pieces with random content, a few broken ones
    task automatic send_value();
        int         pieces;
        int         sel;
        int         n;
        logic [7:0] b;
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) send_item(text_byte(), 1'b0);
            end else if (sel < 40) begin
                send_item(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 3))
                    0: b = CH_N;
                    1: b = CH_T;
                    2: b = CH_R;
                    default: begin
                        do b = 8'($urandom_range(1, 255)); while (b == CH_U);
                    end
                endcase
                send_item(b, 1'b0);
            end else if (sel < 52) begin
                // short form, closed by whatever comes next
                send_text("\\u");
                send_digits($urandom_range(1, 5));
            end else if (sel < 70) begin
                send_text("\\u{");
                send_digits($urandom_range(1, 6));
                send_item(CH_RBRACE, 1'b0);
            end else if (sel < 85) begin
                send_text("${");
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    do b = text_byte(); while (b == CH_RBRACE);
                    send_item(b, 1'b0);
                end
                send_item(CH_RBRACE, 1'b0);
            end else if (sel < 90) begin
                send_item(CH_DOLLAR, 1'b0);
                send_item(text_byte(), 1'b0);
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        send_text("\\u");
                        do b = text_byte(); while (sb.hex_val(b) >= 0 || b == CH_LBRACE);
                        send_item(b, 1'b0);
                    end
                    1: send_text("\\u{}");
                    2: begin
                        send_text("\\u{");
                        send_digits(7);
                        send_item(CH_RBRACE, 1'b0);
                    end
                    3: begin
                        send_text("\\u{");
                        send_digits($urandom_range(0, 3));
                        do b = text_byte(); while (sb.hex_val(b) >= 0 || b == CH_RBRACE);
                        send_item(b, 1'b0);
                        send_item(CH_RBRACE, 1'b0);
                    end
                    4: send_text("${}");
                    default: begin
                        // raw noise, which may itself end the value
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++)
                            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    end
                endcase
            end
        end
        // sometimes the value stops in the middle of an escape or reference
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 7))
                0: send_text("$");
                1: send_text("\\");
                2: send_text("\\u");
                3: send_text("\\u{");
                4: send_text("\\u{1");
                5: send_text("${");
                6: send_text("${ab");
                default: send_text("\\u4");
            endcase
        end
        if ($urandom_range(0, 3) == 0) send_item(8'h00, 1'($urandom_range(0, 1)));
        else send_item(8'($urandom_range(0, 255)), 1'b1);
        values_sent++;
    endtask

    // result side: random back-pressure, every beat goes to the scoreboard
    initial begin
        int gap;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 23) == 0) recv_span = ($urandom_range(0, 3) == 0) ? 0 : 18;
            gap = $urandom_range(0, recv_span);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, sb.beats_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int base;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: escapes, short \u closed by text, a reference, a five-byte code,
        // pending dollar flushed by an end with a junk byte, an error held over an
        // ignored byte and ended by a zero byte, trailing backslash, \u open at end
        send_text("\\t");
        send_text("\\u4g");
        send_text("${k}");
        send_text("\\u{200000}");
        send_text("$");
        send_item(8'hA5, 1'b1);
        send_text("${}z");
        send_item(8'h00, 1'b0);
        send_text("\\");
        send_item(8'hFF, 1'b1);
        send_text("\\u");
        send_item(8'h00, 1'b1);
        drain_results();

        // random values until enough input transactions have gone in
        base = sb.bytes_used;
        while (sb.bytes_used - base < RANDOM_ITEMS) begin
            send_span = ($urandom_range(0, 3) == 0) ? 0 : 18;
            send_value();
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        s_tvalid <= 1'b0;
        while (sb.beats_due.size() > 0) @(posedge aclk);
        // a few more cycles so any stray result still shows up
        repeat (20) @(posedge aclk);

        $display("covered %0d input transactions in %0d values, %0d result transactions",
                 sb.bytes_used, values_sent, sb.beats_seen);
        $display("of which %0d error results and %0d reference-name bytes",
                 sb.error_beats, sb.name_beats);
        if (sb.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/esc_utf8_pkg.sv
hdl/escape_sequence_utf8_decoder.sv
sim/testbench.sv
